### rtl/mtd_pkg.sv
// ----------------------------------------------------------------------------
// mtd_pkg
// Byte codes, widths and the Morse code table for the Morse text decoder.
// ----------------------------------------------------------------------------
package mtd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CHAR_W    = 7;
	localparam int unsigned MAX_SYM   = 6;
	localparam int unsigned LEN_W     = 3;
	localparam int unsigned KEY_W     = MAX_SYM + 1;

	localparam logic [BYTE_W-1:0] BYTE_DOT  = 8'h2E;
	localparam logic [BYTE_W-1:0] BYTE_DASH = 8'h2D;
	localparam logic [BYTE_W-1:0] BYTE_GAP  = 8'h20;

	localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SYM);

	typedef logic [KEY_W-1:0]  mtd_key_t;
	typedef logic [CHAR_W-1:0] mtd_char_t;

	// key: leading marker bit, then symbols first-to-last, dash = 1
	function automatic mtd_char_t mtd_lookup(input mtd_key_t key);
		mtd_char_t ch;
		case (key)
			7'b0000101: ch = 7'h41;
			7'b0011000: ch = 7'h42;
			7'b0011010: ch = 7'h43;
			7'b0001100: ch = 7'h44;
			7'b0000010: ch = 7'h45;
			7'b0010010: ch = 7'h46;
			7'b0001110: ch = 7'h47;
			7'b0010000: ch = 7'h48;
			7'b0000100: ch = 7'h49;
			7'b0010111: ch = 7'h4A;
			7'b0001101: ch = 7'h4B;
			7'b0010100: ch = 7'h4C;
			7'b0000111: ch = 7'h4D;
			7'b0000110: ch = 7'h4E;
			7'b0001111: ch = 7'h4F;
			7'b0010110: ch = 7'h50;
			7'b0011101: ch = 7'h51;
			7'b0001010: ch = 7'h52;
			7'b0001000: ch = 7'h53;
			7'b0000011: ch = 7'h54;
			7'b0001001: ch = 7'h55;
			7'b0010001: ch = 7'h56;
			7'b0001011: ch = 7'h57;
			7'b0011001: ch = 7'h58;
			7'b0011011: ch = 7'h59;
			7'b0011100: ch = 7'h5A;
			7'b0111111: ch = 7'h30;
			7'b0101111: ch = 7'h31;
			7'b0100111: ch = 7'h32;
			7'b0100011: ch = 7'h33;
			7'b0100001: ch = 7'h34;
			7'b0100000: ch = 7'h35;
			7'b0110000: ch = 7'h36;
			7'b0111000: ch = 7'h37;
			7'b0111100: ch = 7'h38;
			7'b0111110: ch = 7'h39;
			7'b1010101: ch = 7'h2E;
			7'b1110011: ch = 7'h2C;
			7'b1001100: ch = 7'h3F;
			7'b1011110: ch = 7'h27;
			7'b1101011: ch = 7'h21;
			7'b0110010: ch = 7'h2F;
			7'b0110110: ch = 7'h28;
			7'b1101101: ch = 7'h29;
			7'b0101000: ch = 7'h26;
			7'b1111000: ch = 7'h3A;
			7'b1101010: ch = 7'h3B;
			7'b0110001: ch = 7'h3D;
			7'b0101010: ch = 7'h2B;
			7'b1100001: ch = 7'h2D;
			7'b1001101: ch = 7'h5F;
			7'b1010010: ch = 7'h22;
			7'b1011010: ch = 7'h40;
			default:    ch = CHAR_NONE;
		endcase
		return ch;
	endfunction

endpackage

### rtl/morse_text_decoder_top.sv
// ----------------------------------------------------------------------------
// morse_text_decoder_top
// Morse text decoder: dots, dashes and gaps in, ASCII characters out.
// ----------------------------------------------------------------------------
// Input channel: item_valid / item_stall carry one word per cycle, made of
// text_byte and message_end. Output channel: result_valid / result_stall
// carry decoded_char, char_valid and last_of_message.
// A word is captured in an input register; once the result register is free,
// the pending code state is updated and the table lookup is done, and any
// result is written to the result register. One word is taken per cycle
// while item_stall is low; words that yield no result (dots, dashes, a gap
// with nothing to decode) still pass through the input register.
// The input register moves on whenever the result register is empty or
// being taken, so item_stall rises only when result_stall holds a pending
// result and the input register is full.
// Reset clears both registers' valid flags and the pending code state.
// An end-of-message word always yields one result and clears the state.
// ----------------------------------------------------------------------------
module morse_text_decoder_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [mtd_pkg::BYTE_W-1:0]   text_byte,
	input  logic                         message_end,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [mtd_pkg::CHAR_W-1:0]   decoded_char,
	output logic                         char_valid,
	output logic                         last_of_message
);
	import mtd_pkg::*;

	logic                  valid_s1;
	logic [BYTE_W-1:0]     byte_s1;
	logic                  end_s1;

	logic [MAX_SYM-1:0]    pattern_bits_q;
	logic [LEN_W-1:0]      pattern_length_q;
	logic                  pattern_spoiled_q;
	logic                  after_gap_q;

	logic                  out_free;
	logic                  fire;
	logic                  in_take;
	mtd_key_t              key;
	mtd_char_t             dec;
	logic                  is_gap;
	logic                  is_sym;
	logic                  emit;
	mtd_char_t             emit_char;
	logic                  emit_cv;

	assign out_free   = !result_valid || !result_stall;
	assign item_stall = valid_s1 && !out_free;
	assign in_take    = item_valid && !item_stall;
	assign fire       = valid_s1 && out_free;

	assign key    = mtd_key_t'(KEY_W'(1) << pattern_length_q) | mtd_key_t'(pattern_bits_q);
	assign is_gap = (byte_s1 == BYTE_GAP);
	assign is_sym = (byte_s1 == BYTE_DOT) || (byte_s1 == BYTE_DASH);

	always_comb begin
		if (pattern_spoiled_q || pattern_length_q == '0 || pattern_length_q > LEN_MAX) begin
			dec = CHAR_NONE;
		end else begin
			dec = mtd_lookup(key);
		end
	end

	always_comb begin
		emit      = 1'b0;
		emit_char = dec;
		emit_cv   = (dec != CHAR_NONE);
		if (end_s1) begin
			emit = 1'b1;
		end else if (is_gap && after_gap_q) begin
			emit      = 1'b1;
			emit_char = CHAR_SPACE;
			emit_cv   = 1'b1;
		end else if (is_gap) begin
			emit = (dec != CHAR_NONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= text_byte;
			end_s1  <= message_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bits_q    <= '0;
			pattern_length_q  <= '0;
			pattern_spoiled_q <= 1'b0;
			after_gap_q       <= 1'b0;
		end else if (fire) begin
			if (end_s1) begin
				pattern_bits_q    <= '0;
				pattern_length_q  <= '0;
				pattern_spoiled_q <= 1'b0;
				after_gap_q       <= 1'b0;
			end else if (is_gap && after_gap_q) begin
				after_gap_q <= 1'b0;
			end else if (is_gap) begin
				pattern_bits_q    <= '0;
				pattern_length_q  <= '0;
				pattern_spoiled_q <= 1'b0;
				after_gap_q       <= 1'b1;
			end else begin
				after_gap_q <= 1'b0;
				if (!is_sym) begin
					pattern_spoiled_q <= 1'b1;
				end else if (pattern_length_q >= LEN_MAX) begin
					pattern_spoiled_q <= 1'b1;
					pattern_length_q  <= LEN_MAX;
				end else begin
					pattern_bits_q   <= {pattern_bits_q[MAX_SYM-2:0], (byte_s1 == BYTE_DASH)};
					pattern_length_q <= pattern_length_q + LEN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			decoded_char    <= emit_char;
			char_valid      <= emit_cv;
			last_of_message <= end_s1;
		end
	end

`ifndef SYNTHESIS
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		pattern_length_q <= LEN_MAX)
		else $error("pattern length out of range");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_s1 |=> pattern_length_q == '0 && !pattern_spoiled_q && !after_gap_q
			&& pattern_bits_q == '0)
		else $error("end of message did not clear state");

	a_empty_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !char_valid |-> last_of_message)
		else $error("empty result outside end of message");

	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && char_valid |-> decoded_char != CHAR_NONE)
		else $error("valid character is zero");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid && result_stall)
		else $error("input stalled without a held result");
`endif

endmodule
